[rtl/gra_pkg.sv]
// Package for the grid region allocator: transaction structs, command codes,
// the memory control group and default parameter values. No dependencies.
package gra_pkg;

  localparam int GRID_SIDE_DEFAULT = 16;

  localparam logic [1:0] CMD_LOCATE    = 2'd0;
  localparam logic [1:0] CMD_MARK      = 2'd1;
  localparam logic [1:0] CMD_CLEAR     = 2'd2;
  localparam logic [1:0] CMD_CLEAR_ALL = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] region_x;
    logic [3:0] region_y;
    logic [4:0] region_width;
    logic [4:0] region_height;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [3:0] found_x;
    logic [3:0] found_y;
  } rsp_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } mem_ctl_t;

endpackage

[rtl/grid_region_allocator_top.sv]
// Top level of the grid region allocator: the sequencer with its row unit and
// the occupancy memory. Depends on gra_pkg, gra_seq and gra_grid_mem.
//
//   port group        direction  handshake
//   request (req_t)   in         start high while busy is low
//   result (rsp_t)    out        done high for one cycle, always taken
//
// Locate reads one memory row per cycle, and each column scan ends in the cycle
// after its last read. Mark and clear read and then write back each grid row touched.
// Clear-all, zero-size requests, oversized locates and marks or clears that start
// outside the grid answer in the next cycle.
// Reset empties the grid at once. The result cannot be stalled; only start waits on busy.
module grid_region_allocator_top #(
  parameter int GRID_SIDE = gra_pkg::GRID_SIDE_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gra_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output gra_pkg::rsp_t result
);
  import gra_pkg::*;

  localparam int RW  = $clog2(GRID_SIDE);
  localparam int RCW = $clog2(GRID_SIDE + 1);
  localparam int SW  = $clog2(2 * GRID_SIDE + 32);

  mem_ctl_t             mctl;
  logic [RW-1:0]        rd_addr;
  logic [RW-1:0]        wr_addr;
  logic [GRID_SIDE-1:0] wr_data;
  logic [GRID_SIDE-1:0] rd_row;

  gra_seq #(
    .GRID_SIDE(GRID_SIDE),
    .RW       (RW),
    .RCW      (RCW),
    .SW       (SW)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result),
    .mctl   (mctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_row (rd_row)
  );

  gra_grid_mem #(
    .GRID_SIDE(GRID_SIDE),
    .RW       (RW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_row (rd_row)
  );

endmodule

[rtl/gra_span_unit.sv]
// Shared row unit: builds the column span of a region and applies it to one
// grid row, giving the occupancy test and the marked and cleared rows.
// Depends on nothing but its parameters.
module gra_span_unit #(
  parameter int GRID_SIDE = 16,
  parameter int SW        = 8
) (
  input  logic [GRID_SIDE-1:0] row_in,
  input  logic [SW-1:0]        x,
  input  logic [SW-1:0]        w,
  output logic                 hit,
  output logic [GRID_SIDE-1:0] set_row,
  output logic [GRID_SIDE-1:0] clr_row
);

  logic [SW-1:0]        x_end;
  logic [GRID_SIDE-1:0] span;

  assign x_end = x + w;

  always_comb begin
    for (int i = 0; i < GRID_SIDE; i++) begin
      span[i] = (SW'(i) >= x) && (SW'(i) < x_end);
    end
  end

  assign hit     = |(row_in & span);
  assign set_row = row_in | span;
  assign clr_row = row_in & ~span;

endmodule

[rtl/gra_grid_mem.sv]
// Occupancy memory: one row of cells per word, one read and one write port,
// registered read data, and a valid bit per row so that reset and clear-all
// empty the grid at once. Depends on gra_pkg.
module gra_grid_mem #(
  parameter int GRID_SIDE = 16,
  parameter int RW        = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gra_pkg::mem_ctl_t    ctl,
  input  logic [RW-1:0]        rd_addr,
  input  logic [RW-1:0]        wr_addr,
  input  logic [GRID_SIDE-1:0] wr_data,
  output logic [GRID_SIDE-1:0] rd_row
);
  import gra_pkg::*;

  logic [GRID_SIDE-1:0] mem [GRID_SIDE];
  logic [GRID_SIDE-1:0] row_valid;
  logic [GRID_SIDE-1:0] rd_data;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (ctl.clr_all) begin
        row_valid <= '0;
      end else if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
    end
  end

  assign rd_row = rd_valid ? rd_data : '0;

endmodule

[rtl/gra_seq.sv]
// Sequencer of the allocator: walks rows and columns through the shared row
// unit for locate, mark and clear, and registers the result.
// Depends on gra_pkg and gra_span_unit.
module gra_seq #(
  parameter int GRID_SIDE = 16,
  parameter int RW        = 4,
  parameter int RCW       = 5,
  parameter int SW        = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  gra_pkg::req_t        request,
  output logic                 busy,
  output logic                 done,
  output gra_pkg::rsp_t        result,
  output gra_pkg::mem_ctl_t    mctl,
  output logic [RW-1:0]        rd_addr,
  output logic [RW-1:0]        wr_addr,
  output logic [GRID_SIDE-1:0] wr_data,
  input  logic [GRID_SIDE-1:0] rd_row
);
  import gra_pkg::*;

  localparam int PW = (RCW > 4) ? RCW : 4;
  localparam logic [SW-1:0]  SIDE_S = SW'(GRID_SIDE);
  localparam logic [RCW-1:0] SIDE_R = RCW'(GRID_SIDE);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_SCAN     = 4'b0010,
    ST_PAINT_RD = 4'b0100,
    ST_PAINT_WR = 4'b1000
  } state_t;

  state_t         state, state_next;
  logic [SW-1:0]  x_q, x_q_next;
  logic [SW-1:0]  x_last, x_last_next;
  logic [SW-1:0]  w_q, w_q_next;
  logic [RCW-1:0] h_q, h_q_next;
  logic [RCW-1:0] run, run_next;
  logic [RCW-1:0] irow, irow_next;
  logic           pend, pend_next;
  logic [RW-1:0]  prow, prow_next;
  logic [RCW-1:0] row_end, row_end_next;
  logic           op_set, op_set_next;
  logic           done_next;
  rsp_t           result_next;

  logic                 hit;
  logic [GRID_SIDE-1:0] set_row;
  logic [GRID_SIDE-1:0] clr_row;
  logic [SW-1:0]        x_ext;
  logic [SW-1:0]        y_ext;
  logic [SW-1:0]        w_ext;
  logic [SW-1:0]        h_ext;
  logic [SW-1:0]        y_end;
  logic [PW-1:0]        fy;
  logic [RCW-1:0]       prow_inc;

  gra_span_unit #(
    .GRID_SIDE(GRID_SIDE),
    .SW       (SW)
  ) u_span (
    .row_in (rd_row),
    .x      (x_q),
    .w      (w_q),
    .hit    (hit),
    .set_row(set_row),
    .clr_row(clr_row)
  );

  assign x_ext    = SW'(request.region_x);
  assign y_ext    = SW'(request.region_y);
  assign w_ext    = SW'(request.region_width);
  assign h_ext    = SW'(request.region_height);
  assign y_end    = y_ext + h_ext;
  assign fy       = PW'(irow - h_q);
  assign prow_inc = RCW'(prow) + RCW'(1);

  assign busy    = (state != ST_IDLE);
  assign rd_addr = (state == ST_SCAN) ? irow[RW-1:0] : prow;
  assign wr_addr = prow;
  assign wr_data = op_set ? set_row : clr_row;

  always_comb begin
    state_next   = state;
    x_q_next     = x_q;
    x_last_next  = x_last;
    w_q_next     = w_q;
    h_q_next     = h_q;
    run_next     = run;
    irow_next    = irow;
    pend_next    = pend;
    prow_next    = prow;
    row_end_next = row_end;
    op_set_next  = op_set;
    done_next    = 1'b0;
    result_next  = result;
    mctl         = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          result_next = '{found: 1'b1, found_x: 4'd0, found_y: 4'd0};
          case (request.command)
            CMD_LOCATE: begin
              if (request.region_width == 5'd0 || request.region_height == 5'd0) begin
                done_next = 1'b1;
              end else if (w_ext > SIDE_S || h_ext > SIDE_S) begin
                done_next         = 1'b1;
                result_next.found = 1'b0;
              end else begin
                state_next  = ST_SCAN;
                x_q_next    = '0;
                x_last_next = SIDE_S - w_ext;
                w_q_next    = w_ext;
                h_q_next    = RCW'(h_ext);
                run_next    = '0;
                irow_next   = '0;
                pend_next   = 1'b0;
              end
            end
            CMD_MARK, CMD_CLEAR: begin
              op_set_next = (request.command == CMD_MARK);
              if (request.region_width == 5'd0 || request.region_height == 5'd0 ||
                  x_ext >= SIDE_S || y_ext >= SIDE_S) begin
                done_next = 1'b1;
              end else begin
                state_next   = ST_PAINT_RD;
                x_q_next     = x_ext;
                w_q_next     = w_ext;
                prow_next    = y_ext[RW-1:0];
                row_end_next = (y_end > SIDE_S) ? SIDE_R : RCW'(y_end);
              end
            end
            default: begin
              mctl.clr_all = 1'b1;
              done_next    = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        mctl.rd_en = (irow != SIDE_R);
        pend_next  = (irow != SIDE_R);
        if (irow != SIDE_R) begin
          irow_next = irow + RCW'(1);
        end
        if (pend) begin
          run_next = hit ? '0 : run + RCW'(1);
          if (!hit && (run + RCW'(1) == h_q)) begin
            state_next  = ST_IDLE;
            done_next   = 1'b1;
            result_next = '{found: 1'b1, found_x: x_q[3:0], found_y: fy[3:0]};
          end else if (irow == SIDE_R) begin
            if (x_q == x_last) begin
              state_next  = ST_IDLE;
              done_next   = 1'b1;
              result_next = '{found: 1'b0, found_x: 4'd0, found_y: 4'd0};
            end else begin
              x_q_next  = x_q + SW'(1);
              irow_next = '0;
              pend_next = 1'b0;
              run_next  = '0;
            end
          end
        end
      end
      ST_PAINT_RD: begin
        mctl.rd_en = 1'b1;
        state_next = ST_PAINT_WR;
      end
      ST_PAINT_WR: begin
        mctl.wr_en = 1'b1;
        if (prow_inc == row_end) begin
          state_next  = ST_IDLE;
          done_next   = 1'b1;
          result_next = '{found: 1'b1, found_x: 4'd0, found_y: 4'd0};
        end else begin
          prow_next  = prow_inc[RW-1:0];
          state_next = ST_PAINT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    x_q     <= x_q_next;
    x_last  <= x_last_next;
    w_q     <= w_q_next;
    h_q     <= h_q_next;
    run     <= run_next;
    irow    <= irow_next;
    prow    <= prow_next;
    row_end <= row_end_next;
    op_set  <= op_set_next;
    result  <= result_next;
  end

endmodule

[rtl/gra_checker.sv]
// Port-level checker for the grid region allocator, bound to the top level.
// Depends on gra_pkg and grid_region_allocator_top.
module gra_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input gra_pkg::req_t request,
  input logic          done,
  input gra_pkg::rsp_t result
);
  import gra_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result delivered while the block is still busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transaction neither started work nor answered");

  a_busy_ends_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.found_x == 4'd0 && result.found_y == 4'd0))
    else $error("failed locate reported a non-zero corner");

  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == CMD_CLEAR_ALL) |=> (done && result.found))
    else $error("clear-all did not complete in one cycle");

endmodule

bind grid_region_allocator_top gra_checker u_gra_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .request(request),
  .done   (done),
  .result (result)
);

[tb/tb_top.sv]
// Self-checking testbench for grid_region_allocator_top: directed, allocation-round and
// random request tests, each checked against a shadow occupancy grid.
// Depends on gra_pkg and the grid_region_allocator_top RTL.
module tb_top;
  import gra_pkg::*;

  localparam int SIDE = GRID_SIDE_DEFAULT;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  request = '0;
  logic  busy;
  logic  done;
  rsp_t  result;

  logic [SIDE-1:0] shadow_grid [SIDE];
  rsp_t pending_results [$];
  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int n_locate = 0;
  int n_hit = 0;
  int n_paint = 0;
  int n_wipe = 0;

  grid_region_allocator_top #(.GRID_SIDE(SIDE)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[grid_region_allocator_top] ERROR");
      $finish;
    end
  end

  function automatic logic [SIDE-1:0] column_mask(input int x, input int w);
    logic [SIDE-1:0] m;
    int i;
    m = '0;
    for (i = 0; i < SIDE; i++)
      if (i >= x && i < x + w) m[i] = 1'b1;
    return m;
  endfunction

  // Applies one request to the shadow grid and returns the result it should give.
  function automatic rsp_t predict_allocation(input req_t r);
    rsp_t rsp;
    logic [SIDE-1:0] span;
    int w, h, cx, cy, row;
    bit fits;
    rsp = '0;
    rsp.found = 1'b1;
    w = int'(r.region_width);
    h = int'(r.region_height);
    case (r.command)
      CMD_LOCATE: begin
        n_locate++;
        if (w != 0 && h != 0) begin
          rsp.found = 1'b0;
          for (cx = 0; cx + w <= SIDE && !rsp.found; cx++) begin
            span = column_mask(cx, w);
            for (cy = 0; cy + h <= SIDE && !rsp.found; cy++) begin
              fits = 1'b1;
              for (row = cy; row < cy + h; row++)
                if ((shadow_grid[row] & span) != '0) fits = 1'b0;
              if (fits) begin
                rsp.found = 1'b1;
                rsp.found_x = cx[3:0];
                rsp.found_y = cy[3:0];
              end
            end
          end
        end
        if (rsp.found) n_hit++;
      end
      CMD_MARK, CMD_CLEAR: begin
        n_paint++;
        span = column_mask(int'(r.region_x), w);
        for (row = int'(r.region_y); row < int'(r.region_y) + h && row < SIDE; row++) begin
          if (r.command == CMD_MARK) shadow_grid[row] = shadow_grid[row] | span;
          else shadow_grid[row] = shadow_grid[row] & ~span;
        end
      end
      default: begin
        n_wipe++;
        foreach (shadow_grid[i]) shadow_grid[i] = '0;
      end
    endcase
    return rsp;
  endfunction

  function automatic req_t make_request(input logic [1:0] cmd, input int x, input int y,
                                        input int w, input int h);
    req_t r;
    r.command = cmd;
    r.region_x = x[3:0];
    r.region_y = y[3:0];
    r.region_width = w[4:0];
    r.region_height = h[4:0];
    return r;
  endfunction

  function automatic int draw_extent();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 4);
    if (sel < 90) return $urandom_range(5, 10);
    if (sel < 98) return $urandom_range(11, 16);
    if (sel == 98) return 0;
    return $urandom_range(17, 31);
  endfunction

  // Presents one request, waits for the transaction and records the expected result.
  // Between bursts the sender may drop start for a random gap.
  task automatic issue_request(input req_t r, output rsp_t predicted);
    int gap;
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_allocation(r);
    pending_results.push_back(predicted);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: gap = $urandom_range(1, 3);
        1: gap = $urandom_range(4, 30);
        2: gap = $urandom_range(31, 300);
        default: gap = 0;
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic test_directed_cases();
    rsp_t p;
    issue_request(make_request(CMD_LOCATE, 0, 0, 0, 0), p);
    issue_request(make_request(CMD_LOCATE, 15, 15, 0, 7), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 16, 16), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 17, 1), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 31, 31), p);
    issue_request(make_request(CMD_MARK, 0, 0, 16, 16), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 1, 1), p);
    issue_request(make_request(CMD_CLEAR, 15, 15, 1, 1), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 1, 1), p);
    issue_request(make_request(CMD_CLEAR, 12, 3, 31, 31), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 4, 13), p);
    issue_request(make_request(CMD_MARK, 15, 15, 31, 31), p);
    issue_request(make_request(CMD_MARK, 3, 3, 0, 9), p);
    issue_request(make_request(CMD_CLEAR, 3, 3, 9, 0), p);
    issue_request(make_request(CMD_CLEAR_ALL, 15, 15, 31, 31), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 16, 16), p);
    issue_request(make_request(CMD_MARK, 0, 0, 1, 16), p);
    issue_request(make_request(CMD_LOCATE, 15, 15, 1, 1), p);
    issue_request(make_request(CMD_MARK, 1, 0, 15, 15), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 15, 1), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 2, 2), p);
    issue_request(make_request(CMD_CLEAR_ALL, 0, 0, 0, 0), p);
    issue_request(make_request(CMD_MARK, 0, 5, 16, 1), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 16, 5), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 16, 11), p);
    issue_request(make_request(CMD_LOCATE, 0, 0, 16, 10), p);
  endtask

  // Locate then mark the region found, freeing regions now and then, so that the grid
  // fills up and locates have to search far.
  task automatic test_allocation_rounds(input int n_items);
    req_t r;
    rsp_t p;
    req_t held [$];
    int sent, pick, k;
    sent = 0;
    while (sent < n_items) begin
      r = make_request(CMD_LOCATE, $urandom_range(0, 15), $urandom_range(0, 15),
                       draw_extent(), draw_extent());
      issue_request(r, p);
      sent++;
      if (p.found && r.region_width != 0 && r.region_height != 0) begin
        r.command = CMD_MARK;
        r.region_x = p.found_x;
        r.region_y = p.found_y;
        issue_request(r, p);
        sent++;
        held.push_back(r);
      end else if ($urandom_range(0, 1) == 0 && held.size() != 0) begin
        for (k = 0; k < 3 && held.size() != 0; k++) begin
          pick = $urandom_range(0, held.size() - 1);
          r = held[pick];
          r.command = CMD_CLEAR;
          held.delete(pick);
          issue_request(r, p);
          sent++;
        end
      end else if (!p.found) begin
        issue_request(make_request(CMD_CLEAR_ALL, $urandom_range(0, 15),
                                   $urandom_range(0, 15), $urandom_range(0, 31),
                                   $urandom_range(0, 31)), p);
        sent++;
        held.delete();
      end
      if (held.size() != 0 && $urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, held.size() - 1);
        r = held[pick];
        r.command = CMD_CLEAR;
        held.delete(pick);
        issue_request(r, p);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        r = make_request(2'($urandom_range(CMD_MARK, CMD_CLEAR)), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 31),
                         $urandom_range(0, 31));
        issue_request(r, p);
        sent++;
      end
    end
  endtask

  task automatic test_random_requests(input int n_items);
    rsp_t p;
    int i;
    for (i = 0; i < n_items; i++)
      issue_request(make_request(2'($urandom_range(CMD_LOCATE, CMD_CLEAR_ALL)),
                                 $urandom_range(0, 15),
                                 $urandom_range(0, 15), $urandom_range(0, 31),
                                 $urandom_range(0, 31)), p);
  endtask

  always @(posedge clk) begin : check_results
    rsp_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: found=%0d found_x=%0d found_y=%0d",
               result.found, result.found_x, result.found_y);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, result.found);
          errors++;
        end
        if (result.found_x !== want.found_x) begin
          $error("found_x: expected %0d, actual %0d", want.found_x, result.found_x);
          errors++;
        end
        if (result.found_y !== want.found_y) begin
          $error("found_y: expected %0d, actual %0d", want.found_y, result.found_y);
          errors++;
        end
      end
    end
  end

  initial begin
    foreach (shadow_grid[i]) shadow_grid[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_allocation_rounds(800);
    test_random_requests(300);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    $display("Covered %0d locates (%0d found), %0d mark or clear and %0d clear-all transactions",
             n_locate, n_hit, n_paint, n_wipe);
    $display("in %0d cycles with %0d mismatches.", cycle_count, errors);
    if (errors == 0) begin
      $display("[grid_region_allocator_top] OK");
    end else begin
      $display("[grid_region_allocator_top] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/gra_pkg.sv
rtl/gra_span_unit.sv
rtl/gra_grid_mem.sv
rtl/gra_seq.sv
rtl/grid_region_allocator_top.sv
rtl/gra_checker.sv
tb/tb_top.sv
